// ===== rtl/trg_pkg.sv =====
// Shared types, constants and helpers for the readability grade block.
`default_nettype none

package trg_pkg;

  // Counter width and derived datapath widths
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = 16;
  localparam int GRADE_W     = 11;
  localparam int MULT_K_BITS = 12;
  localparam int PROD_W      = COUNT_BITS + MULT_K_BITS;
  localparam int ACC_W       = PROD_W + 2;
  localparam int MAG_W       = COUNT_BITS + 13;
  localparam int DVS_W       = COUNT_BITS + 8;
  localparam int REM_W       = COUNT_BITS + 15;
  localparam int QUO_BITS    = GRADE_W + 1;
  localparam int DSH_W       = DVS_W + QUO_BITS - 1;
  localparam int BIT_CNT_W   = $clog2(QUO_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Coleman-Liau coefficients, scaled by 100 (denominator scaled by 2 for rounding)
  localparam logic [MULT_K_BITS-1:0] K_LETTER   = MULT_K_BITS'(588);
  localparam logic [MULT_K_BITS-1:0] K_SENTENCE = MULT_K_BITS'(2960);
  localparam logic [MULT_K_BITS-1:0] K_WORD     = MULT_K_BITS'(1580);
  localparam logic [MULT_K_BITS-1:0] K_DIVISOR  = MULT_K_BITS'(200);

  localparam logic signed [GRADE_W-1:0] GRADE_MAX = GRADE_W'(1023);
  localparam logic signed [GRADE_W-1:0] GRADE_MIN = GRADE_W'(-1024);
  localparam logic signed [GRADE_W-1:0] GRADE_LOW = GRADE_W'(1);
  localparam logic signed [GRADE_W-1:0] GRADE_TOP = GRADE_W'(16);

  // ASCII codes
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
  localparam logic [7:0] CHAR_EXCLAIM = 8'h21;
  localparam logic [7:0] CHAR_QUERY   = 8'h3F;

  typedef enum logic [1:0] {
    CLASS_LOW  = 2'd0,
    CLASS_MID  = 2'd1,
    CLASS_HIGH = 2'd2
  } trg_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LETTER,
    ST_MUL_SENTENCE,
    ST_MUL_WORD,
    ST_MUL_DIVISOR,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } trg_state_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } trg_in_word_t;

  typedef struct packed {
    logic signed [GRADE_W-1:0] grade;
    logic [1:0]                grade_class;
    logic [TOTAL_BITS-1:0]     letter_total;
    logic [TOTAL_BITS-1:0]     word_total;
    logic [TOTAL_BITS-1:0]     sentence_total;
  } trg_out_word_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] letters;
    logic [COUNT_BITS-1:0] words;
    logic [COUNT_BITS-1:0] sentences;
  } trg_counts_t;

  typedef struct packed {
    logic signed [GRADE_W-1:0] grade;
    logic [1:0]                grade_class;
  } trg_result_t;

  // Clamp a count to the 16-bit total field
  function automatic logic [TOTAL_BITS-1:0] sat_total(logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+TOTAL_BITS-1:0] w;
    logic [COUNT_BITS+TOTAL_BITS-1:0] lim;
    w   = (COUNT_BITS+TOTAL_BITS)'(v);
    lim = (COUNT_BITS+TOTAL_BITS)'({TOTAL_BITS{1'b1}});
    if (w > lim) begin
      return {TOTAL_BITS{1'b1}};
    end
    return w[TOTAL_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trg_grade_unit.sv =====
// Sequenced grade computation: one shared constant multiplier, then a restoring divider.
`default_nettype none

module trg_grade_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire trg_pkg::trg_counts_t counts_i,
  input  wire logic                 ack_i,
  output logic                      idle_o,
  output logic                      done_o,
  output trg_pkg::trg_result_t      result_o
);
  import trg_pkg::*;

  trg_state_e state_q, state_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [DVS_W-1:0]        dvs_q, dvs_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [DSH_W-1:0]        dsh_q, dsh_d;
  logic [QUO_BITS-1:0]     quo_q, quo_d;
  logic                    neg_q, neg_d;

  // shared multiplier
  logic [COUNT_BITS-1:0]  mul_a;
  logic [MULT_K_BITS-1:0] mul_k;
  logic [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0] prod_s;

  logic [MAG_W-1:0] mag;
  logic [DSH_W-1:0] rem_ext;
  logic             fits;

  logic [GRADE_W-1:0]        q_low;
  logic signed [GRADE_W-1:0] grade;

  always_comb begin
    mul_a = counts_i.letters;
    mul_k = K_LETTER;
    case (state_q)
      ST_MUL_SENTENCE: begin
        mul_a = counts_i.sentences;
        mul_k = K_SENTENCE;
      end
      ST_MUL_WORD: begin
        mul_a = counts_i.words;
        mul_k = K_WORD;
      end
      ST_MUL_DIVISOR: begin
        mul_a = counts_i.words;
        mul_k = K_DIVISOR;
      end
      default: begin
        mul_a = counts_i.letters;
        mul_k = K_LETTER;
      end
    endcase
    prod   = PROD_W'(mul_a) * PROD_W'(mul_k);
    prod_s = $signed({2'b00, prod});
  end

  assign mag     = MAG_W'(acc_q[ACC_W-1] ? -acc_q : acc_q);
  assign rem_ext = DSH_W'(rem_q);
  assign fits    = (rem_ext >= dsh_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MUL_LETTER;
        end
      end
      ST_MUL_LETTER: begin
        acc_d   = prod_s;
        state_d = ST_MUL_SENTENCE;
      end
      ST_MUL_SENTENCE: begin
        acc_d   = acc_q - prod_s;
        state_d = ST_MUL_WORD;
      end
      ST_MUL_WORD: begin
        acc_d   = acc_q - prod_s;
        state_d = ST_MUL_DIVISOR;
      end
      ST_MUL_DIVISOR: begin
        dvs_d   = prod[DVS_W-1:0];
        state_d = ST_PREP;
      end
      ST_PREP: begin
        // dividend 2|num| + den, divisor 2*den: quotient is the rounded magnitude
        neg_d   = acc_q[ACC_W-1];
        rem_d   = REM_W'({mag, 1'b0}) + REM_W'(dvs_q >> 1);
        dsh_d   = DSH_W'(dvs_q) << (QUO_BITS - 1);
        quo_d   = '0;
        cnt_d   = BIT_CNT_W'(QUO_BITS - 1);
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (fits) begin
          rem_d = REM_W'(rem_ext - dsh_q);
        end
        quo_d = {quo_q[QUO_BITS-2:0], fits};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - BIT_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // Top quotient bit set means the magnitude is 2048 or more: saturate.
  always_comb begin
    q_low = quo_q[GRADE_W-1:0];
    if (!neg_q) begin
      if (quo_q[QUO_BITS-1] || quo_q[GRADE_W-1]) begin
        grade = GRADE_MAX;
      end else begin
        grade = $signed(q_low);
      end
    end else begin
      if (quo_q[QUO_BITS-1] || (quo_q[GRADE_W-1] && (quo_q[GRADE_W-2:0] != '0))) begin
        grade = GRADE_MIN;
      end else begin
        grade = $signed(-q_low);
      end
    end
    result_o.grade = grade;
    if (grade < GRADE_LOW) begin
      result_o.grade_class = CLASS_LOW;
    end else if (grade > GRADE_TOP) begin
      result_o.grade_class = CLASS_HIGH;
    end else begin
      result_o.grade_class = CLASS_MID;
    end
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/text_readability_grade_core.sv =====
// Top level of the Coleman-Liau readability grade block.
`default_nettype none

// Counts letters, whitespace and sentence ends of a text arriving one byte
// per word on the input channel, at one byte per cycle. When the byte
// flagged last_byte is taken, the input stalls while the grade is worked
// out by a small sequencer around one shared constant multiplier and a
// restoring divider: a multiply step each for the letter, sentence, word
// and divisor terms, a setup step, a divide step for each of the 12
// quotient bits and a hand-off to the output register, which waits while
// the output register is still held by a stalled earlier result. The output
// word carries the rounded grade (saturated to -1024..1023), its class and
// the three totals (saturated to 65535); the counters clear as the result
// is loaded. Nothing else needs setup after reset.
module text_readability_grade_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire trg_pkg::trg_in_word_t  in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output trg_pkg::trg_out_word_t      out_data_o
);
  import trg_pkg::*;

  // running counters
  logic [COUNT_BITS-1:0] letter_q, letter_d;
  logic [COUNT_BITS-1:0] space_q, space_d;
  logic [COUNT_BITS-1:0] sentence_q, sentence_d;
  logic [COUNT_BITS-1:0] words;

  logic in_fire;
  logic is_letter, is_space, is_sentence;
  logic [7:0] c;

  // grade unit handshake
  trg_counts_t counts;
  trg_result_t result;
  logic        unit_idle;
  logic        unit_done;
  logic        out_free;
  logic        load;

  // output register
  logic          out_valid_q, out_valid_d;
  trg_out_word_t out_data_q;

  assign in_stall_o = !unit_idle;
  assign in_fire    = in_valid_i && !in_stall_o;

  // byte classification, first match wins as letters, spaces, sentence ends
  assign c           = in_data_i.char_byte;
  assign is_letter   = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                       ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  assign is_space    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_sentence = (c == CHAR_PERIOD) || (c == CHAR_EXCLAIM) || (c == CHAR_QUERY);

  // word count is spaces plus one, held at the counter maximum
  assign words = (space_q == COUNT_MAX) ? COUNT_MAX : space_q + COUNT_BITS'(1);

  // result moves into the output register when that register is free
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = unit_done && out_free;

  always_comb begin
    letter_d   = letter_q;
    space_d    = space_q;
    sentence_d = sentence_q;
    if (load) begin
      letter_d   = '0;
      space_d    = '0;
      sentence_d = '0;
    end else if (in_fire) begin
      if (is_letter) begin
        if (letter_q != COUNT_MAX) letter_d = letter_q + COUNT_BITS'(1);
      end else if (is_space) begin
        if (space_q != COUNT_MAX) space_d = space_q + COUNT_BITS'(1);
      end else if (is_sentence) begin
        if (sentence_q != COUNT_MAX) sentence_d = sentence_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q   <= '0;
      space_q    <= '0;
      sentence_q <= '0;
    end else begin
      letter_q   <= letter_d;
      space_q    <= space_d;
      sentence_q <= sentence_d;
    end
  end

  assign counts.letters   = letter_q;
  assign counts.words     = words;
  assign counts.sentences = sentence_q;

  trg_grade_unit u_grade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire && in_data_i.last_byte),
    .counts_i (counts),
    .ack_i    (out_free),
    .idle_o   (unit_idle),
    .done_o   (unit_done),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.grade          <= result.grade;
      out_data_q.grade_class    <= result.grade_class;
      out_data_q.letter_total   <= sat_total(letter_q);
      out_data_q.word_total     <= sat_total(words);
      out_data_q.sentence_total <= sat_total(sentence_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A last byte always hands off to the grade unit, which blocks the input.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_byte) |=> in_stall_o)
    else $error("input not stalled after last byte");

  // Counters start fresh for the next text once a result is loaded.
  a_clear_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ((letter_q == '0) && (space_q == '0) && (sentence_q == '0)))
    else $error("counters not cleared after result load");

  // A high class must agree with the grade it was derived from.
  a_class_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.grade_class == CLASS_HIGH)) |-> (out_data_o.grade > GRADE_TOP))
    else $error("high class with grade of 16 or less");

  // Word total includes the implicit first word.
  a_words_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.word_total != '0))
    else $error("word total of zero");

endmodule

`default_nettype wire

// ===== tb/trg_checker.sv =====
// Scoreboard for the readability grade block: predicts each result word and compares it.
module trg_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  trg_pkg::trg_in_word_t  in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  trg_pkg::trg_out_word_t out_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     text_count_o,
  output int                     low_count_o,
  output int                     mid_count_o,
  output int                     high_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import trg_pkg::*;

  localparam longint GRADE_FLOOR = -1024;
  localparam longint GRADE_CEIL  = 1023;

  logic [COUNT_BITS-1:0] letter_cnt;
  logic [COUNT_BITS-1:0] space_cnt;
  logic [COUNT_BITS-1:0] sentence_cnt;
  trg_out_word_t         grade_q[$];
  trg_out_word_t         want;
  logic [7:0]            ch;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    text_count_o = 0;
    low_count_o  = 0;
    mid_count_o  = 0;
    high_count_o = 0;
  end

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOTAL_BITS-1:0] clip_total(input logic [COUNT_BITS-1:0] v);
    longint unsigned w;
    w = v;
    return (w > 64'hFFFF) ? '1 : TOTAL_BITS'(w);
  endfunction

  // Exact integer Coleman-Liau, halves rounded away from zero
  function automatic trg_out_word_t grade_text(input logic [COUNT_BITS-1:0] letters,
                                               input logic [COUNT_BITS-1:0] sentences,
                                               input logic [COUNT_BITS-1:0] spaces);
    longint        words;
    longint        num;
    longint        den;
    longint        mag;
    longint        q;
    longint        g;
    trg_out_word_t r;
    words = longint'(bump(spaces));
    num   = 588 * longint'(letters) - 2960 * longint'(sentences) - 1580 * words;
    den   = 100 * words;
    mag   = (num < 0) ? -num : num;
    q     = (2 * mag + den) / (2 * den);
    g     = (num < 0) ? -q : q;
    if (g < GRADE_FLOOR) g = GRADE_FLOOR;
    if (g > GRADE_CEIL) g = GRADE_CEIL;
    r.grade = GRADE_W'(g);
    if (g < 1) begin
      r.grade_class = CLASS_LOW;
    end else if (g > 16) begin
      r.grade_class = CLASS_HIGH;
    end else begin
      r.grade_class = CLASS_MID;
    end
    r.letter_total   = clip_total(letters);
    r.word_total     = clip_total(bump(spaces));
    r.sentence_total = clip_total(sentences);
    return r;
  endfunction

  task automatic note_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_cnt   = '0;
      space_cnt    = '0;
      sentence_cnt = '0;
      grade_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        ch = in_data_i.char_byte;
        if ((ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
            (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)) begin
          letter_cnt = bump(letter_cnt);
        end else if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR)) begin
          space_cnt = bump(space_cnt);
        end else if (ch == CHAR_PERIOD || ch == CHAR_EXCLAIM || ch == CHAR_QUERY) begin
          sentence_cnt = bump(sentence_cnt);
        end
        if (in_data_i.last_byte) begin
          grade_q.push_back(grade_text(letter_cnt, sentence_cnt, space_cnt));
          letter_cnt   = '0;
          space_cnt    = '0;
          sentence_cnt = '0;
          text_count_o++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (grade_q.size() == 0) begin
          $error("result word with no text pending: grade %0d", out_data_i.grade);
          fail_count_o++;
        end else begin
          want = grade_q.pop_front();
          note_field("grade", want.grade, out_data_i.grade);
          note_field("grade_class", want.grade_class, out_data_i.grade_class);
          note_field("letter_total", want.letter_total, out_data_i.letter_total);
          note_field("word_total", want.word_total, out_data_i.word_total);
          note_field("sentence_total", want.sentence_total, out_data_i.sentence_total);
          case (want.grade_class)
            CLASS_LOW:  low_count_o++;
            CLASS_MID:  mid_count_o++;
            default:    high_count_o++;
          endcase
        end
      end
    end
    pending_o = grade_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the readability grade block: stimulus, receiver stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trg_pkg::*;

  // Enough letters in one word to clamp the grade high, enough sentence
  // ends to clamp it low (quotient overflows the divider there).
  localparam int HIGH_TEXT_LEN = 200;
  localparam int LOW_TEXT_LEN  = 360;
  localparam int RANDOM_BYTES  = 1000;
  // Even if every byte ended a text, each waits for the grade unit plus gaps
  // and receiver stalls; this leaves a wide margin.
  localparam int CYCLE_LIMIT   = 200_000;
  // Extra margin for the grade after the last byte; allow for receiver stalls too.
  localparam int DRAIN_CYCLES  = 80;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  trg_in_word_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  trg_out_word_t out_data;

  int          fail_count;
  int          pending;
  int          text_count;
  int          low_count;
  int          mid_count;
  int          high_count;
  int unsigned cycle_count = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  int          burst_left  = 0;
  int          random_bytes = 0;
  logic [7:0]  text_q[$];

  text_readability_grade_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  trg_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .text_count_o (text_count),
    .low_count_o  (low_count),
    .mid_count_o  (mid_count),
    .high_count_o (high_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stall: mode is redrawn periodically from the cycle counter, so some stretches never stall
  // and others hold results back hard while new bytes keep arriving.
  always @(posedge clk) begin
    if (cycle_count[8:0] == 9'd0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        default:      out_stall <= ~out_stall;
      endcase
    end
  end

  // One byte per word. Bursts of random length with idle gaps, at times none, in between;
  // some bursts are long and gapless. Valid is only lowered for a real gap,
  // so it never gets two assignments in one step.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) begin
        burst_left = 200;
      end else begin
        burst_left = $urandom_range(4, 40);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_data.char_byte  <= ch;
    in_data.last_byte  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) begin
      return CHAR_LOWER_A + 8'($urandom_range(0, 25));
    end
    return CHAR_UPPER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 3) != 0) begin
      return CHAR_SPACE;
    end
    return CHAR_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] rand_stop();
    case ($urandom_range(0, 2))
      0:       return CHAR_PERIOD;
      1:       return CHAR_EXCLAIM;
      default: return CHAR_QUERY;
    endcase
  endfunction

  // Mostly prose-like texts: words with a per-text length limit so that grades
  // land in all three classes, some sentence ends, a little stray noise.
  // One text in seven is raw bytes over the full 0..255 range.
  task automatic build_random_text();
    int max_len;
    int n_words;
    text_q.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      max_len = $urandom_range(1, 12);
      n_words = $urandom_range(1, 10);
      for (int w = 0; w < n_words; w++) begin
        if (w != 0) begin
          text_q.push_back(rand_blank());
          if ($urandom_range(0, 7) == 0) text_q.push_back(rand_blank());
        end
        repeat ($urandom_range(1, max_len)) text_q.push_back(rand_letter());
        if ($urandom_range(0, 3) == 0) text_q.push_back(rand_stop());
        if ($urandom_range(0, 15) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic build_long_text(input logic [7:0] ch, input int len);
    text_q.delete();
    repeat (len) text_q.push_back(ch);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty text: a lone last byte, one word, grade -16.
    text_q = '{8'h00};
    send_text();

    // Class boundaries: the letter range ends but lowercase a, whitespace ends, the other
    // sentence ends, neighbors of the letter and whitespace ranges and the high half of the byte.
    text_q = '{CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_LOWER_Z, CHAR_TAB, CHAR_CR, CHAR_EXCLAIM,
               CHAR_QUERY, 8'h08, 8'h0E, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF, 8'h00};
    send_text();

    // "ab cde..." lands exactly on -45.5, rounding away from zero to -46.
    text_q = '{8'h61, 8'h62, CHAR_SPACE, 8'h63, 8'h64, 8'h65,
               CHAR_PERIOD, CHAR_PERIOD, CHAR_PERIOD};
    send_text();

    // Grade clamps: one long word (clamps high), sentence ends only (clamps low).
    build_long_text(CHAR_LOWER_Z, HIGH_TEXT_LEN);
    send_text();
    build_long_text(CHAR_PERIOD, LOW_TEXT_LEN);
    send_text();

    while (random_bytes < RANDOM_BYTES) begin
      build_random_text();
      random_bytes += text_q.size();
      send_text();
    end
    in_valid <= 1'b0;

    // One more edge so the checker has logged the final text before draining.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Graded %0d texts: edge cases, both grade clamps and %0d random bytes.",
             text_count, random_bytes);
    $display("Grade classes checked: %0d low, %0d mid, %0d high.", low_count, mid_count, high_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
